// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL that checks its own behavior (the segmenter top).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/core/rlcseg_pkg.sv -----
`default_nettype none
package rlcseg_pkg;

	localparam int LEN_W     = 14;
	localparam int SEQ_W     = 10;
	localparam int SLOT_W    = 4;
	localparam int HDR_W     = 5;
	localparam int FI_W      = 2;
	localparam int LI_W      = 11;
	localparam int SEG_CAP   = 16;
	localparam int SEG_IDX_W = 4;
	localparam int SEG_CNT_W = 5;
	localparam int LI_LIMIT  = 2048;

	localparam logic OP_ENQ   = 1'b0;
	localparam logic OP_GRANT = 1'b1;

	typedef struct packed {
		logic enq;
		logic grant_init;
		logic step;
		logic emit;
		logic emit_empty;
	} seg_cmd_t;

	typedef struct packed {
		logic pack_stop;
		logic n_zero;
		logic emit_last;
	} seg_stat_t;

	// Header size in bytes for a PDU carrying segs explicit length indicators.
	function automatic logic [HDR_W-1:0] hdr_bytes(input logic [SEG_CNT_W-1:0] segs);
		logic [7:0] sum;
		sum = 8'd23 + 8'(segs) * 8'd12;
		return sum[7:3];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rlc_am_pdu_segmenter_unit.sv -----
// RLC acknowledged-mode PDU segmenter.
// Input: a transaction is accepted on a rising edge where start is high and busy
// is low. opcode 0 queues an SDU length, opcode 1 is a grant of grant_bytes.
// Output: each result is shown for one cycle with result_valid high; the receiver
// cannot stall it and must take it in that cycle. last_result marks the final
// result of a transaction.
// An enqueue returns one result in the next cycle and leaves busy low, so one
// enqueue can be accepted every cycle.
// A grant placing k segments passes one check and one pack state per segment,
// since each segment waits on the registered read of the descriptor memory,
// then a closing check, then an emit state that shows the stored segments in
// turn. A zero-length head SDU that ends packing costs one more check and pack
// step. A grant that places nothing returns one empty result after its closing
// check. busy stays high until the last result is loaded.
// Reset empties the queue, clears the partly sent head SDU and the sequence
// number, and needs no clearing pass over the descriptor memory.
`default_nettype none
`include "assert_macros.svh"
module rlc_am_pdu_segmenter_unit
	import rlcseg_pkg::*;
#(
	parameter int QUEUE_DEPTH     = 16,
	parameter int MAX_SDU_BYTES   = 9000,
	parameter int MAX_GRANT_BYTES = 9000
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [LEN_W-1:0]  sdu_length,
	input  wire logic [LEN_W-1:0]  grant_bytes,
	output logic                   result_valid,
	output logic [SEQ_W-1:0]       pdu_sequence,
	output logic [FI_W-1:0]        framing_info,
	output logic [HDR_W-1:0]       header_bytes,
	output logic [SLOT_W-1:0]      segment_slot,
	output logic [LEN_W-1:0]       segment_offset,
	output logic [LEN_W-1:0]       segment_length,
	output logic                   extension_bit,
	output logic [LI_W-1:0]        length_indicator,
	output logic                   empty_grant,
	output logic                   enqueue_dropped,
	output logic                   last_result
);

	seg_cmd_t  cmd;
	seg_stat_t stat;

	rlcseg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rlcseg_dp #(
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.MAX_SDU_BYTES   (MAX_SDU_BYTES),
		.MAX_GRANT_BYTES (MAX_GRANT_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sdu_length       (sdu_length),
		.grant_bytes      (grant_bytes),
		.stat             (stat),
		.result_valid     (result_valid),
		.pdu_sequence     (pdu_sequence),
		.framing_info     (framing_info),
		.header_bytes     (header_bytes),
		.segment_slot     (segment_slot),
		.segment_offset   (segment_offset),
		.segment_length   (segment_length),
		.extension_bit    (extension_bit),
		.length_indicator (length_indicator),
		.empty_grant      (empty_grant),
		.enqueue_dropped  (enqueue_dropped),
		.last_result      (last_result)
	);

	`ASSERT_NEXT(a_enq_result, start && !busy && (opcode == OP_ENQ), result_valid && last_result)
	`ASSERT_SAME(a_empty_is_last, result_valid && empty_grant, last_result && !extension_bit)
	`ASSERT_SAME(a_more_pending, result_valid && !last_result, busy && extension_bit)
	`ASSERT_SAME(a_one_command, 1'b1, $onehot0(cmd))

endmodule
`default_nettype wire

// ----- rtl/core/rlcseg_ctrl.sv -----
`default_nettype none
module rlcseg_ctrl
	import rlcseg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      opcode,
	input  wire seg_stat_t stat,
	output seg_cmd_t       cmd,
	output logic           busy
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_STEP  = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_ENQ) begin
						cmd.enq = 1'b1;
					end else begin
						cmd.grant_init = 1'b1;
						state_d        = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (!stat.pack_stop) begin
					state_d = S_STEP;
				end else if (stat.n_zero) begin
					cmd.emit_empty = 1'b1;
					state_d        = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_CHECK;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rlcseg_dp.sv -----
`default_nettype none
module rlcseg_dp
	import rlcseg_pkg::*;
#(
	parameter int QUEUE_DEPTH     = 16,
	parameter int MAX_SDU_BYTES   = 9000,
	parameter int MAX_GRANT_BYTES = 9000
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire seg_cmd_t          cmd,
	input  wire logic [LEN_W-1:0]  sdu_length,
	input  wire logic [LEN_W-1:0]  grant_bytes,
	output seg_stat_t              stat,
	output logic                   result_valid,
	output logic [SEQ_W-1:0]       pdu_sequence,
	output logic [FI_W-1:0]        framing_info,
	output logic [HDR_W-1:0]       header_bytes,
	output logic [SLOT_W-1:0]      segment_slot,
	output logic [LEN_W-1:0]       segment_offset,
	output logic [LEN_W-1:0]       segment_length,
	output logic                   extension_bit,
	output logic [LI_W-1:0]        length_indicator,
	output logic                   empty_grant,
	output logic                   enqueue_dropped,
	output logic                   last_result
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ROOM_W = LEN_W + 2;

	logic [LEN_W-1:0]     queue_mem [QUEUE_DEPTH];
	logic [LEN_W-1:0]     head_len_q;
	logic [PTR_W-1:0]     rptr_q;
	logic [PTR_W-1:0]     wptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [LEN_W-1:0]     consumed_q;
	logic [SEQ_W-1:0]     next_seq_q;
	logic [LEN_W-1:0]     grant_q;
	logic [LEN_W-1:0]     total_q;
	logic [SEG_CNT_W-1:0] n_q;
	logic [LEN_W-1:0]     last_len_q;
	logic                 halt_q;
	logic                 started_q;
	logic [SEG_IDX_W-1:0] emit_idx_q;

	logic [PTR_W-1:0]     seg_slot_q [SEG_CAP];
	logic [LEN_W-1:0]     seg_off_q  [SEG_CAP];
	logic [LEN_W-1:0]     seg_len_q  [SEG_CAP];

	logic                  full;
	logic                  do_write;
	logic [LEN_W-1:0]      sdu_sat;
	logic [LEN_W-1:0]      grant_sat;
	logic signed [ROOM_W-1:0] room;
	logic                  room_pos;
	logic [LEN_W-1:0]      rem;
	logic [LEN_W-1:0]      take;
	logic                  zero_head;
	logic                  pop;
	logic [PTR_W-1:0]      rptr_next;
	logic [PTR_W-1:0]      wptr_next;
	logic [PTR_W+SLOT_W-1:0] slot_wide;
	logic [HDR_W-1:0]      hdr_final;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_write  = cmd.enq && !full;
	assign sdu_sat   = (sdu_length > LEN_W'(MAX_SDU_BYTES)) ? LEN_W'(MAX_SDU_BYTES) : sdu_length;
	assign grant_sat = (grant_bytes > LEN_W'(MAX_GRANT_BYTES)) ?
		LEN_W'(MAX_GRANT_BYTES) : grant_bytes;

	assign room = $signed({2'b00, grant_q}) - $signed({{(ROOM_W-HDR_W){1'b0}}, hdr_bytes(n_q)})
		- $signed({2'b00, total_q});
	assign room_pos = !room[ROOM_W-1] && (room != '0);

	assign rem       = (head_len_q > consumed_q) ? (head_len_q - consumed_q) : '0;
	assign take      = (room[LEN_W-1:0] < rem) ? room[LEN_W-1:0] : rem;
	assign zero_head = (consumed_q == '0) && (head_len_q == '0);
	assign pop       = cmd.step && (zero_head || (take >= rem));

	assign rptr_next = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
	assign wptr_next = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;

	assign stat.pack_stop = halt_q || (n_q == SEG_CNT_W'(SEG_CAP)) || !room_pos
		|| ((n_q != '0) && (last_len_q >= LEN_W'(LI_LIMIT))) || (count_q == '0);
	assign stat.n_zero    = (n_q == '0);
	assign stat.emit_last = ((SEG_CNT_W'(emit_idx_q) + 1'b1) == n_q);

	assign slot_wide = {{SLOT_W{1'b0}}, seg_slot_q[emit_idx_q]};
	assign hdr_final = hdr_bytes(n_q - 1'b1);

	always_ff @(posedge clk) begin
		if (do_write) begin
			queue_mem[wptr_q] <= sdu_sat;
		end
		head_len_q <= queue_mem[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.step && !zero_head) begin
			seg_slot_q[n_q[SEG_IDX_W-1:0]] <= rptr_q;
			seg_off_q[n_q[SEG_IDX_W-1:0]]  <= consumed_q;
			seg_len_q[n_q[SEG_IDX_W-1:0]]  <= take;
			last_len_q                     <= take;
		end
		if (cmd.grant_init) begin
			grant_q <= grant_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q       <= '0;
			wptr_q       <= '0;
			count_q      <= '0;
			consumed_q   <= '0;
			next_seq_q   <= '0;
			total_q      <= '0;
			n_q          <= '0;
			halt_q       <= 1'b0;
			started_q    <= 1'b0;
			emit_idx_q   <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.enq || cmd.emit || cmd.emit_empty;
			if (do_write) begin
				wptr_q  <= wptr_next;
				count_q <= count_q + 1'b1;
			end
			if (cmd.grant_init) begin
				total_q    <= '0;
				n_q        <= '0;
				halt_q     <= 1'b0;
				started_q  <= (consumed_q != '0);
				emit_idx_q <= '0;
			end
			if (cmd.step) begin
				if (zero_head) begin
					halt_q <= 1'b1;
				end else begin
					total_q <= total_q + take;
					n_q     <= n_q + 1'b1;
				end
				if (pop) begin
					rptr_q     <= rptr_next;
					count_q    <= count_q - 1'b1;
					consumed_q <= '0;
				end else begin
					consumed_q <= consumed_q + take;
				end
			end
			if (cmd.emit) begin
				emit_idx_q <= emit_idx_q + 1'b1;
				if (stat.emit_last) begin
					next_seq_q <= next_seq_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq || cmd.emit_empty) begin
			pdu_sequence     <= cmd.emit_empty ? next_seq_q : '0;
			framing_info     <= '0;
			header_bytes     <= '0;
			segment_slot     <= '0;
			segment_offset   <= '0;
			segment_length   <= '0;
			extension_bit    <= 1'b0;
			length_indicator <= '0;
			empty_grant      <= cmd.emit_empty;
			enqueue_dropped  <= cmd.enq && full;
			last_result      <= 1'b1;
		end else if (cmd.emit) begin
			pdu_sequence     <= next_seq_q;
			framing_info     <= {started_q, (consumed_q != '0)};
			header_bytes     <= hdr_final;
			segment_slot     <= slot_wide[SLOT_W-1:0];
			segment_offset   <= seg_off_q[emit_idx_q];
			segment_length   <= seg_len_q[emit_idx_q];
			extension_bit    <= !stat.emit_last;
			length_indicator <= stat.emit_last ? '0 : seg_len_q[emit_idx_q][LI_W-1:0];
			empty_grant      <= 1'b0;
			enqueue_dropped  <= 1'b0;
			last_result      <= stat.emit_last;
		end
	end

endmodule
`default_nettype wire
